// File: rtl/palette_dual_hash_check_defines.svh
// Assertion helpers shared by the RTL.
// Each use expects signals named clk and rst_n in scope.
`ifndef PALETTE_DUAL_HASH_CHECK_DEFINES_SVH
`define PALETTE_DUAL_HASH_CHECK_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PDHC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define PDHC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// File: rtl/pdhc_pkg.sv
package pdhc_pkg;

    localparam logic [31:0] CRC_POLY  = 32'hedb8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_CRC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_FNV = 2'd1;

    // one queued byte word, tagged with its end-of-stream class
    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } pdhc_item_t;

    // reflected CRC-32, one byte, bitwise form flattens to an XOR network
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    // FNV-1a step, product kept mod 2^32
    function automatic logic [31:0] fnv_byte(input logic [31:0] h,
                                             input logic [7:0]  data);
        logic [31:0] x;
        x = h ^ {24'd0, data};
        return x * FNV_PRIME;
    endfunction

endpackage

// File: rtl/palette_dual_hash_check.sv
// palette_dual_hash_check: CRC-32 and FNV-1a checksums over a byte stream.
//
// Input channel s_axis_*: one byte per word in tdata[7:0], tlast on the
// final byte of a stream. A stream holds at least one byte.
// Output channel m_axis_*: one word per stream, raised after the last byte:
// tdata[31:0] final CRC-32, tdata[63:32] FNV-1a hash, tuser holds the
// match flags against the expected values.
// Config channel cfg_*: index 0 expected CRC, index 1 expected FNV; other
// indices are dropped. Always ready; write only while the block is idle.
//
// Throughput: one byte per cycle while no held-off result stalls the flow.
// The byte-wide CRC network and the constant FNV multiply sit in one
// back-end stage that retires a byte each cycle it is not stalled. Path:
// input register, queue, hash stage, compare stage, then the result word.
// Reset: hashes return to their initial values, queue and output empty,
// expected values cleared to zero.
// Stall: a held-off result word stays put; bytes keep flowing into the
// hash stage until a further end-of-stream result cannot move, then the
// queue fills and s_axis_tready drops.
`include "palette_dual_hash_check_defines.svh"

module palette_dual_hash_check
    import pdhc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
    input  logic                 s_axis_tlast,   // last_byte

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [31:0] crc_value, [63:32] fnv_value
    output logic [2:0]           m_axis_tuser,   // [0] crc_match, [1] fnv_match, [2] both_match

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic [31:0] exp_crc_reg, exp_crc_next;
    logic [31:0] exp_fnv_reg, exp_fnv_next;

    logic       push, queue_full, queue_ne, pop;
    pdhc_item_t push_item, head_item;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        exp_crc_next = exp_crc_reg;
        exp_fnv_next = exp_fnv_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EXPECTED_CRC: exp_crc_next = cfg_data;
                REG_EXPECTED_FNV: exp_fnv_next = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_crc_reg <= '0;
            exp_fnv_reg <= '0;
        end
        else
        begin
            exp_crc_reg <= exp_crc_next;
            exp_fnv_reg <= exp_fnv_next;
        end
    end

    // front: takes bytes, tags end of stream
    pdhc_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // decoupling queue
    pdhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .not_empty (queue_ne),
        .full      (queue_full)
    );

    // back: hashing, compare, result word
    pdhc_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (head_item),
        .item_valid    (queue_ne),
        .item_pop      (pop),
        .expected_crc  (exp_crc_reg),
        .expected_fnv  (exp_fnv_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // front must never write into a full queue, back never pops an empty one
    `PDHC_NEVER(a_no_overflow, push && queue_full, "push into full queue")
    `PDHC_NEVER(a_no_underflow, pop && !queue_ne, "pop from empty queue")

endmodule

// File: rtl/pdhc_front.sv
module pdhc_front
    import pdhc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    input  logic       queue_full,
    output logic       push,
    output pdhc_item_t push_item
);

    logic       hold_valid_reg, hold_valid_next;
    pdhc_item_t hold_item_reg, hold_item_next;
    logic       accept;

    assign push          = hold_valid_reg && !queue_full;
    assign s_axis_tready = !hold_valid_reg || !queue_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push_item     = hold_item_reg;

    always_comb
    begin
        hold_valid_next = accept ? 1'b1 : (push ? 1'b0 : hold_valid_reg);
        hold_item_next  = hold_item_reg;
        if (accept)
        begin
            hold_item_next.data_byte = s_axis_tdata;
            hold_item_next.last_byte = s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        hold_item_reg <= hold_item_next;
    end

endmodule

// File: rtl/pdhc_queue.sv
`include "palette_dual_hash_check_defines.svh"

module pdhc_queue
    import pdhc_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pdhc_item_t push_item,
    input  logic       pop,
    output pdhc_item_t head_item,
    output logic       not_empty,
    output logic       full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pdhc_item_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             wr_en, rd_en;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign wr_en     = push && !full;
    assign rd_en     = pop && not_empty;
    assign head_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            count_next = count_reg + 1'b1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // occupancy tracks the pointers
    `PDHC_ASSERT(a_cnt_up, wr_en && !rd_en |=> count_reg == $past(count_reg) + 1'b1, "queue count did not rise on write")
    `PDHC_NEVER(a_cnt_range, count_reg > CNT_FULL, "queue count above depth")

endmodule

// File: rtl/pdhc_back.sv
`include "palette_dual_hash_check_defines.svh"

module pdhc_back
    import pdhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pdhc_item_t  item,
    input  logic        item_valid,
    output logic        item_pop,
    input  logic [31:0] expected_crc,
    input  logic [31:0] expected_fnv,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] crc_value, [63:32] fnv_value
    output logic [2:0]  m_axis_tuser    // [0] crc_match, [1] fnv_match, [2] both_match
);

    // running hashes
    logic [31:0] crc_reg, crc_next;
    logic [31:0] fnv_reg, fnv_next;
    logic [31:0] crc_step, fnv_step;

    // finished hashes awaiting compare
    logic        res_valid_reg, res_valid_next;
    logic [31:0] res_crc_reg, res_crc_next;
    logic [31:0] res_fnv_reg, res_fnv_next;

    // output word
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [2:0]  out_user_reg, out_user_next;

    logic out_load, res_adv, res_free, crc_hit, fnv_hit;

    assign out_load = !out_valid_reg || m_axis_tready;
    assign res_adv  = res_valid_reg && out_load;
    assign res_free = !res_valid_reg || out_load;
    assign item_pop = item_valid && res_free;

    assign crc_step = crc_byte(crc_reg, item.data_byte);
    assign fnv_step = fnv_byte(fnv_reg, item.data_byte);

    assign crc_hit = (res_crc_reg == expected_crc);
    assign fnv_hit = (res_fnv_reg == expected_fnv);

    always_comb
    begin
        crc_next       = crc_reg;
        fnv_next       = fnv_reg;
        res_valid_next = res_adv ? 1'b0 : res_valid_reg;
        res_crc_next   = res_crc_reg;
        res_fnv_next   = res_fnv_reg;
        if (item_pop)
        begin
            if (item.last_byte)
            begin
                crc_next       = CRC_INIT;
                fnv_next       = FNV_BASIS;
                res_valid_next = 1'b1;
                res_crc_next   = ~crc_step;
                res_fnv_next   = fnv_step;
            end
            else
            begin
                crc_next = crc_step;
                fnv_next = fnv_step;
            end
        end
    end

    always_comb
    begin
        out_valid_next = res_adv ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (res_adv)
        begin
            out_data_next = {res_fnv_reg, res_crc_reg};
            out_user_next = {crc_hit & fnv_hit, fnv_hit, crc_hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= CRC_INIT;
            fnv_reg       <= FNV_BASIS;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            fnv_reg       <= fnv_next;
            res_valid_reg <= res_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_crc_reg  <= res_crc_next;
        res_fnv_reg  <= res_fnv_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // hashes restart after each end-of-stream byte
    `PDHC_ASSERT(a_restart, item_pop && item.last_byte |=> crc_reg == CRC_INIT && fnv_reg == FNV_BASIS, "hashes not restarted after last byte")

endmodule

// File: bench/palette_dual_hash_check_test.sv
`timescale 1ns / 1ps

import pdhc_pkg::*;

// One expected digest word, as it should leave the master side.
typedef struct packed {
    logic [31:0] crc_value;
    logic [31:0] fnv_value;
    logic        crc_match;
    logic        fnv_match;
    logic        both_match;
} digest_t;

// Reflected CRC-32, fed one data bit at a time (LSB first).
function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++)
    begin
        fb = r[0] ^ d[i];
        r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
    end
    return r;
endfunction

// FNV-1a: xor the byte in, multiply by the prime, keep the low 32 bits.
function automatic logic [31:0] fnv_next(input logic [31:0] h, input logic [7:0] d);
    logic [63:0] p;
    p = {32'd0, h ^ {24'd0, d}} * {32'd0, FNV_PRIME};
    return p[31:0];
endfunction

// Final sums of a whole stream: [31:0] CRC-32, [63:32] FNV-1a.
function automatic logic [63:0] sums_of(input logic [7:0] s[$]);
    logic [31:0] c;
    logic [31:0] h;
    c = CRC_INIT;
    h = FNV_BASIS;
    foreach (s[i])
    begin
        c = crc_next(c, s[i]);
        h = fnv_next(h, s[i]);
    end
    return {h, ~c};
endfunction

class hash_scoreboard;
    logic [31:0] crc_run;
    logic [31:0] fnv_run;
    logic [31:0] crc_want;
    logic [31:0] fnv_want;
    digest_t     digests[$];
    int          errors;

    function new();
        crc_run  = CRC_INIT;
        fnv_run  = FNV_BASIS;
        crc_want = 32'd0;
        fnv_want = 32'd0;
        errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        case (idx)
            REG_EXPECTED_CRC: crc_want = data;
            REG_EXPECTED_FNV: fnv_want = data;
            default: ;
        endcase
    endfunction

    function void note_byte(logic [7:0] d, logic last);
        digest_t dg;
        crc_run = crc_next(crc_run, d);
        fnv_run = fnv_next(fnv_run, d);
        if (last)
        begin
            dg.crc_value  = ~crc_run;
            dg.fnv_value  = fnv_run;
            dg.crc_match  = (dg.crc_value == crc_want);
            dg.fnv_match  = (dg.fnv_value == fnv_want);
            dg.both_match = dg.crc_match & dg.fnv_match;
            digests.push_back(dg);
            crc_run = CRC_INIT;
            fnv_run = FNV_BASIS;
        end
    endfunction

    task report(string what);
        if (errors < 100)
            $display("MISMATCH: %s", what);
        errors++;
    endtask

    task check_digest(logic [63:0] data, logic [2:0] flags);
        digest_t dg;
        if (digests.size() == 0)
        begin
            report($sformatf("unexpected digest word crc=%h fnv=%h", data[31:0], data[63:32]));
            return;
        end
        dg = digests.pop_front();
        if (data[31:0] !== dg.crc_value)
            report($sformatf("crc_value %h, want %h", data[31:0], dg.crc_value));
        if (data[63:32] !== dg.fnv_value)
            report($sformatf("fnv_value %h, want %h", data[63:32], dg.fnv_value));
        if (flags[0] !== dg.crc_match)
            report($sformatf("crc_match %b, want %b", flags[0], dg.crc_match));
        if (flags[1] !== dg.fnv_match)
            report($sformatf("fnv_match %b, want %b", flags[1], dg.fnv_match));
        if (flags[2] !== dg.both_match)
            report($sformatf("both_match %b, want %b", flags[2], dg.both_match));
    endtask
endclass

module palette_dual_hash_check_test;

    // Indices the block has no register behind; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam int RANDOM_BYTES = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 8;      // extra wait for the pipe to empty after the last digest
    localparam int HOLD_CYCLES  = 150;    // long master-side hold-off
    localparam int CALM_STREAMS = 16;     // streams in the no-idle stretch

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic                 s_axis_tlast = 1'b0;   // last_byte

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [63:0]          m_axis_tdata;          // [31:0] crc_value, [63:32] fnv_value
    logic [2:0]           m_axis_tuser;          // [0] crc_match, [1] fnv_match, [2] both_match

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = 32'd0;

    hash_scoreboard sb = new();

    // Steering between the stimulus thread and the sink.
    bit tx_calm = 1'b0;     // sender never idles
    bit rx_calm = 1'b0;     // sink never idles
    bit hold_req = 1'b0;    // ask the sink for its one long hold-off
    bit hold_done = 1'b0;
    int hold_left = 0;
    int cycles = 0;

    palette_dual_hash_check u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Sink: checks every digest word taken, then picks next cycle's tready.
    // Once asked, it holds tready low for a long stretch so that the block's
    // queue fills up and s_axis_tready drops.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_digest(m_axis_tdata, m_axis_tuser);
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= rx_calm || ($urandom_range(0, 99) >= 33);
        end
    end

    // One byte word on the slave side; returns at the edge that takes it.
    // tvalid is only ever lowered here when a gap follows.
    task send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = 0;
        while (!tx_calm && $urandom_range(0, 99) < 33)
            gap++;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_byte(d, last);
    endtask

    // Send a run of bytes; tlast goes on the final one only if close is set.
    task send_bytes(input logic [7:0] s[$], input bit close);
        foreach (s[i])
            send_byte(s[i], close && (i == s.size() - 1));
    endtask

    // Stop sending, let every digest drain, then give the pipe time to empty.
    task quiesce();
        s_axis_tvalid <= 1'b0;
        while (sb.digests.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        if (r < 16)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short streams, now and then a longer one.
    function automatic void make_stream(ref logic [7:0] s[$], input bit short_only);
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (short_only || r < 80)
            len = $urandom_range(1, short_only ? 3 : 6);
        else if (r < 95)
            len = $urandom_range(7, 20);
        else
            len = $urandom_range(21, 40);
        s.delete();
        repeat (len) s.push_back(pick_byte());
    endfunction

    initial
    begin
        logic [7:0]  s[$];
        logic [7:0]  head[$];
        logic [63:0] sums;
        int          sent;
        int          phase;
        int          mode;
        int          n_streams;
        int          waited;
        bit          pressure;

        sent  = 0;
        phase = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----

        // single zero byte against reset values (both zero): no match
        s = '{8'h00};
        send_bytes(s, 1'b1);

        // the classic check string, both registers primed to match
        s = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        sums = sums_of(s);
        quiesce();
        write_reg(REG_EXPECTED_CRC, sums[31:0]);
        write_reg(REG_EXPECTED_FNV, sums[63:32]);
        send_bytes(s, 1'b1);

        // all-ones byte: CRC matches, FNV register at its top extreme
        s = '{8'hff};
        sums = sums_of(s);
        quiesce();
        write_reg(REG_EXPECTED_CRC, sums[31:0]);
        write_reg(REG_EXPECTED_FNV, 32'hffff_ffff);
        send_bytes(s, 1'b1);

        // FNV only matches
        s = '{8'h80, 8'h01};
        sums = sums_of(s);
        quiesce();
        write_reg(REG_EXPECTED_CRC, 32'hffff_ffff);
        write_reg(REG_EXPECTED_FNV, sums[63:32]);
        send_bytes(s, 1'b1);

        // registers rewritten part way through a stream, plus writes to the
        // spare indices that must leave both registers alone
        s = '{8'ha5, 8'h5a, 8'hc3};
        sums = sums_of(s);
        head = '{8'ha5, 8'h5a};
        quiesce();
        send_bytes(head, 1'b0);
        quiesce();
        write_reg(REG_EXPECTED_CRC, sums[31:0]);
        write_reg(REG_EXPECTED_FNV, 32'd0);
        write_reg(REG_SPARE_LO, 32'hffff_ffff);
        write_reg(REG_SPARE_HI, 32'h1234_5678);
        head = '{8'hc3};
        send_bytes(head, 1'b1);

        // ---- random phases ----
        while (sent < RANDOM_BYTES)
        begin
            phase++;
            pressure = (phase == 4);
            make_stream(s, pressure);
            sums = sums_of(s);
            quiesce();

            // one stretch with no idling at all, and the pressure phase with
            // a sender that never lets up
            tx_calm = (phase == 7) || pressure;
            rx_calm = (phase == 7);

            mode = $urandom_range(0, 6);
            case (mode)
                0:
                begin
                    write_reg(REG_EXPECTED_CRC, $urandom());
                    write_reg(REG_EXPECTED_FNV, $urandom());
                end
                1:
                begin
                    write_reg(REG_EXPECTED_FNV, 32'd0);
                    write_reg(REG_EXPECTED_CRC, 32'd0);
                end
                2:
                begin
                    write_reg(REG_EXPECTED_CRC, 32'hffff_ffff);
                    write_reg(REG_EXPECTED_FNV, 32'hffff_ffff);
                end
                3:
                begin
                    write_reg(REG_EXPECTED_CRC, sums[31:0]);
                    write_reg(REG_EXPECTED_FNV, sums[63:32]);
                end
                4:
                begin
                    write_reg(REG_EXPECTED_CRC, sums[31:0]);
                    write_reg(REG_EXPECTED_FNV, $urandom());
                end
                5:
                begin
                    write_reg(REG_EXPECTED_FNV, sums[63:32]);
                    write_reg(REG_EXPECTED_CRC, $urandom());
                end
                default:
                begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom());
                end
            endcase

            if (pressure)
            begin
                hold_req = 1'b1;
                n_streams = 30;
            end
            else if (phase == 7)
                n_streams = CALM_STREAMS;
            else
                n_streams = $urandom_range(1, 6);

            send_bytes(s, 1'b1);
            sent += s.size();
            for (int k = 1; k < n_streams; k++)
            begin
                make_stream(s, pressure);
                send_bytes(s, 1'b1);
                sent += s.size();
            end
        end

        // ---- drain ----
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.digests.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2 * SETTLE) @(posedge clk);
        if (sb.digests.size() != 0)
            sb.report($sformatf("%0d digest words never arrived", sb.digests.size()));

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pdhc_pkg.sv
rtl/pdhc_front.sv
rtl/pdhc_queue.sv
rtl/pdhc_back.sv
rtl/palette_dual_hash_check.sv
bench/palette_dual_hash_check_test.sv
